@@ src/bcache_pkg.sv @@
// bcache_pkg: widths, register indexes and shared types of the block cache
// with access-count replacement. No dependencies; every other file imports it.
package bcache_pkg;

  // Sizing
  localparam int SLOTS      = 2;
  localparam int MAX_BLOCKS = 1024;
  localparam int COUNT_BITS = 16;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BLK_W   = 10;
  localparam int BCNT_W  = 11;
  localparam int SCNT_W  = 2;
  localparam int TOTAL_W = 32;
  localparam int FLUSH_W = COUNT_BITS + 1 + SLOT_W;
  localparam int ADD_W   = ((FLUSH_W > TOTAL_W) ? FLUSH_W : TOTAL_W) + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

  localparam logic [SCNT_W-1:0]    SLOTS_RESET  = 2'd2;
  localparam logic [BCNT_W-1:0]    BLOCKS_RESET = 11'd1024;
  localparam logic [BCNT_W-1:0]    BLOCKS_MAX   = BCNT_W'(MAX_BLOCKS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX    = '1;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the request
    logic eval;    // look up tags, pick victim, sum counters
    logic commit;  // update slot state, load the response register
  } cmd_t;

endpackage

@@ src/bcache_if.sv @@
// bcache_if: valid/ready channel interfaces for requests, responses and
// configuration writes. Depends on bcache_pkg for field widths.
interface bcache_req_if;
  import bcache_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [BLK_W-1:0] block_index;
  modport source (output valid, op, block_index, input ready);
  modport sink   (input valid, op, block_index, output ready);
endinterface

interface bcache_rsp_if;
  import bcache_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               slot;
  logic               writeback;
  logic [BLK_W-1:0]   writeback_block;
  logic               range_error;
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] miss_total;
  modport source (output valid, hit, slot, writeback, writeback_block, range_error,
                  hit_total, miss_total, input ready);
  modport sink   (input valid, hit, slot, writeback, writeback_block, range_error,
                  hit_total, miss_total, output ready);
endinterface

interface bcache_cfg_if;
  import bcache_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/bcache_ctrl.sv @@
// bcache_ctrl: sequencer for one request at a time (idle, evaluate, commit)
// and owner of the response valid flag. Depends on bcache_pkg.
module bcache_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              rsp_ready_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  output bcache_pkg::cmd_t  cmd_o
);
  import bcache_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COMMIT
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;
  logic   commit_go;
  logic   req_fire;

  // Commit only when the response register is free or being drained
  assign commit_go   = (state_q == S_COMMIT) && (!rsp_valid_q || rsp_ready_i);
  // A new request may enter in the same cycle the previous one commits
  assign req_ready_o = (state_q == S_IDLE) || commit_go;
  assign req_fire    = req_valid_i && req_ready_o;

  assign cmd_o.load   = req_fire;
  assign cmd_o.eval   = (state_q == S_EVAL);
  assign cmd_o.commit = commit_go;
  assign rsp_valid_o  = rsp_valid_q;

  // State and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_fire) state_q <= S_EVAL;
        end
        S_EVAL: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit_go) state_q <= req_fire ? S_EVAL : S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (commit_go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ src/bcache_dp.sv @@
// bcache_dp: slot tags, access counters, dirty marks, totals, configuration
// registers and the response register. Depends on bcache_pkg.
module bcache_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bcache_pkg::cmd_t                    cmd_i,
  input  logic                                req_op_i,
  input  logic [bcache_pkg::BLK_W-1:0]        req_block_i,
  input  logic                                cfg_valid_i,
  input  logic [bcache_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bcache_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                                cfg_ready_o,
  output logic                                rsp_hit_o,
  output logic                                rsp_slot_o,
  output logic                                rsp_writeback_o,
  output logic [bcache_pkg::BLK_W-1:0]        rsp_wb_block_o,
  output logic                                rsp_range_error_o,
  output logic [bcache_pkg::TOTAL_W-1:0]      rsp_hit_total_o,
  output logic [bcache_pkg::TOTAL_W-1:0]      rsp_miss_total_o
);
  import bcache_pkg::*;

  // Configuration registers
  logic [SCNT_W-1:0] slots_q;
  logic [BCNT_W-1:0] blocks_q;

  // Slot state
  logic [BLK_W-1:0]      tag_q    [SLOTS];
  logic [COUNT_BITS-1:0] reads_q  [SLOTS];
  logic [COUNT_BITS-1:0] writes_q [SLOTS];
  logic [SLOTS-1:0]      dirty_q;
  logic [TOTAL_W-1:0]    hits_q;
  logic [TOTAL_W-1:0]    misses_q;

  // Captured request and evaluation results
  logic               op_q;
  logic [BLK_W-1:0]   blk_q;
  logic               rerr_q;
  logic               hit_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [FLUSH_W-1:0] flush_q;

  // Evaluation logic
  logic [SLOTS-1:0]   active;
  logic [BCNT_W-1:0]  limit;
  logic               rerr_d;
  logic               hit_d;
  logic [SLOT_W-1:0]  hit_slot;
  logic [SLOT_W-1:0]  best;
  logic [FLUSH_W-1:0] flush_d;

  // Commit logic
  logic [ADD_W-1:0]   hits_sum;
  logic [TOTAL_W-1:0] hits_next;
  logic [TOTAL_W-1:0] misses_next;
  logic               do_hit;
  logic               do_miss;

  assign cfg_ready_o = 1'b1;

  // Active slots: slot 0 always, others below the configured count
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      active[i] = (i == 0) || (int'(slots_q) > i);
    end
  end

  assign limit  = (blocks_q > BLOCKS_MAX) ? BLOCKS_MAX : blocks_q;
  assign rerr_d = (BCNT_W'(blk_q) >= limit);

  // Tag search: lowest active matching slot wins
  always_comb begin
    hit_d    = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit_d && active[i] && (tag_q[i] == blk_q)) begin
        hit_d    = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  // Victim scan from slot 0
  always_comb begin
    best = '0;
    for (int i = 1; i < SLOTS; i++) begin
      if (active[i] &&
          (((writes_q[i] != '0) && (writes_q[i] < writes_q[best])) ||
           ((writes_q[i] == '0) && (reads_q[i] < reads_q[best])))) begin
        best = SLOT_W'(i);
      end
    end
  end

  // Sum of all active counters for the miss flush
  always_comb begin
    flush_d = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (active[i]) begin
        flush_d = flush_d + FLUSH_W'(reads_q[i]) + FLUSH_W'(writes_q[i]);
      end
    end
  end

  // Totals after this request
  assign do_hit   = !rerr_q && hit_q;
  assign do_miss  = !rerr_q && !hit_q;
  assign hits_sum = ADD_W'(hits_q) + ADD_W'(flush_q);
  assign hits_next = !do_miss ? hits_q :
                     (hits_sum > ADD_W'(TOTAL_MAX)) ? TOTAL_MAX : hits_sum[TOTAL_W-1:0];
  assign misses_next = !do_miss ? misses_q :
                       (misses_q == TOTAL_MAX) ? TOTAL_MAX : misses_q + 1'b1;

  // Configuration, slot state and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= SLOTS_RESET;
      blocks_q <= BLOCKS_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        tag_q[i]    <= BLK_W'(i);
        reads_q[i]  <= '0;
        writes_q[i] <= '0;
      end
      dirty_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SLOTS_IN_USE:  slots_q  <= cfg_data_i[SCNT_W-1:0];
          CFG_BLOCKS_IN_USE: blocks_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (cmd_i.commit && do_hit) begin
        if (op_q == OP_WRITE) begin
          if (writes_q[slot_q] != COUNT_MAX) writes_q[slot_q] <= writes_q[slot_q] + 1'b1;
          dirty_q[slot_q] <= 1'b1;
        end else begin
          if (reads_q[slot_q] != COUNT_MAX) reads_q[slot_q] <= reads_q[slot_q] + 1'b1;
        end
      end

      if (cmd_i.commit && do_miss) begin
        // Flush active counters, then refill the victim and count the access
        for (int i = 0; i < SLOTS; i++) begin
          if (active[i]) begin
            reads_q[i]  <= '0;
            writes_q[i] <= '0;
          end
        end
        tag_q[slot_q]    <= blk_q;
        dirty_q[slot_q]  <= (op_q == OP_WRITE);
        writes_q[slot_q] <= COUNT_BITS'(op_q == OP_WRITE);
        reads_q[slot_q]  <= COUNT_BITS'(op_q == OP_READ);
        hits_q           <= hits_next;
        misses_q         <= misses_next;
      end
    end
  end

  // Request capture and evaluation stage (payload only)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_op_i;
      blk_q <= req_block_i;
    end
    if (cmd_i.eval) begin
      rerr_q  <= rerr_d;
      hit_q   <= hit_d;
      slot_q  <= hit_d ? hit_slot : best;
      flush_q <= flush_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_hit_o         <= do_hit;
      rsp_slot_o        <= rerr_q ? 1'b0 : slot_q[0];
      rsp_writeback_o   <= do_miss && dirty_q[slot_q];
      rsp_wb_block_o    <= do_miss ? tag_q[slot_q] : '0;
      rsp_range_error_o <= rerr_q;
      rsp_hit_total_o   <= hits_next;
      rsp_miss_total_o  <= misses_next;
    end
  end

endmodule

@@ src/block_cache_access_count_replacement.sv @@
// block_cache_access_count_replacement: top level of the block cache with
// access-count replacement. Depends on bcache_pkg, bcache_if, bcache_ctrl, bcache_dp.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    op, block_index
//   rsp_o    out  valid/ready    hit, slot, writeback, writeback_block,
//                                range_error, hit_total, miss_total
//   cfg_i    in   valid/ready    index (0 slots_in_use, 1 blocks_in_use), data
//
// Each request has an evaluate step, which searches tags, picks the victim and sums
// the counters, and a commit step, which updates slot state and loads the response
// register. A new request is taken in the commit step of the previous one, so
// back-to-back requests overlap. The response register stalls the commit step while a
// response is still waiting. Reset restores slot i to block i, zero counters.
module block_cache_access_count_replacement (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcache_req_if.sink   req_i,
  bcache_rsp_if.source rsp_o,
  bcache_cfg_if.sink   cfg_i
);
  import bcache_pkg::*;

  cmd_t cmd;

  bcache_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  bcache_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .req_op_i          (req_i.op),
    .req_block_i       (req_i.block_index),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .cfg_ready_o       (cfg_i.ready),
    .rsp_hit_o         (rsp_o.hit),
    .rsp_slot_o        (rsp_o.slot),
    .rsp_writeback_o   (rsp_o.writeback),
    .rsp_wb_block_o    (rsp_o.writeback_block),
    .rsp_range_error_o (rsp_o.range_error),
    .rsp_hit_total_o   (rsp_o.hit_total),
    .rsp_miss_total_o  (rsp_o.miss_total)
  );

`ifndef SYNTHESIS
  // One request in flight: no new request right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while previous one still evaluating");

  // A hit or a range error never reports a writeback
  a_no_wb_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.hit || rsp_o.range_error)) |-> !rsp_o.writeback)
    else $error("writeback flagged on hit or range error");

  // Miss total never decreases from one shown response to the next
  a_miss_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && $past(rsp_o.valid)) |-> (rsp_o.miss_total >= $past(rsp_o.miss_total)))
    else $error("miss total decreased");
`endif

endmodule
